@@ hw/rtl/tcpck_pkg.sv @@
// Shared types, constants and the end-around-carry fold for the TCP/IPv4 checksum generator.
// No dependencies.
`timescale 1ns / 1ps

package tcpck_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
	localparam logic [16:0] MAX_PAYLOAD = 17'd65495;
	localparam logic [15:0] HDR_BYTES = 16'd40;
	localparam logic [15:0] IP_HDR_BYTES = 16'd20;
	localparam logic [15:0] LEN_SAT = 16'hFFFF;

	// version/ihl + id + ttl/proto
	localparam logic [21:0] IP_CONST_SUM = 22'h4500 + 22'h1234 + 22'hFF06;
	// flags/offset + window + proto
	localparam logic [21:0] TCP_CONST_SUM = 22'h5018 + 22'h2000 + 22'h0006;

	typedef struct packed {
		logic [15:0] sum;
		logic [16:0] count;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [31:0] ports;
	} seg_desc_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

	function automatic logic [15:0] fold16(logic [21:0] s);
		logic [16:0] t;
		t = {1'b0, s[15:0]} + {11'b0, s[21:16]};
		return t[15:0] + {15'b0, t[16]};
	endfunction

endpackage

@@ hw/rtl/tcpck_front.sv @@
// Front end: accepts payload bytes, latches addresses, keeps the running sum and count.
// Depends on tcpck_pkg.
`timescale 1ns / 1ps

module tcpck_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            payload_byte,
	input  logic                  last_byte,
	input  logic [31:0]           source_ip,
	input  logic [31:0]           dest_ip,
	input  logic [15:0]           source_port,
	input  logic [15:0]           dest_port,
	output logic                  push,
	output tcpck_pkg::seg_desc_t  desc
);
	import tcpck_pkg::*;

	logic        in_seg_q;
	logic        odd_q;
	logic [7:0]  held_q;
	logic [15:0] sum_q;
	logic [16:0] count_q;
	logic [31:0] src_q, dst_q, ports_q;

	logic        first;
	logic        odd_base;
	logic [15:0] sum_base, sum_new, word;
	logic [16:0] cnt_base, cnt_new;

	always_comb begin
		first    = ~in_seg_q;
		odd_base = first ? 1'b0 : odd_q;
		sum_base = first ? 16'h0 : sum_q;
		cnt_base = first ? 17'h0 : count_q;
		word     = odd_base ? {held_q, payload_byte} : {payload_byte, 8'h00};
		if (odd_base || last_byte) begin
			sum_new = fold16({6'b0, sum_base} + {6'b0, word});
		end else begin
			sum_new = sum_base;
		end
		cnt_new = (cnt_base < COUNT_MAX) ? cnt_base + 17'd1 : cnt_base;
	end

	always_comb begin
		push         = accept & last_byte;
		desc.sum     = sum_new;
		desc.count   = cnt_new;
		desc.src_ip  = first ? source_ip : src_q;
		desc.dst_ip  = first ? dest_ip : dst_q;
		desc.ports   = first ? {source_port, dest_port} : ports_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_seg_q <= 1'b0;
			odd_q    <= 1'b0;
		end else if (accept) begin
			in_seg_q <= ~last_byte;
			odd_q    <= ~odd_base & ~last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q   <= sum_new;
			count_q <= cnt_new;
			if (!odd_base) begin
				held_q <= payload_byte;
			end
			if (first) begin
				src_q   <= source_ip;
				dst_q   <= dest_ip;
				ports_q <= {source_port, dest_port};
			end
		end
	end

endmodule

@@ hw/rtl/tcpck_fifo.sv @@
// Short queue of finished segment descriptors between front and back end.
// Depends on tcpck_pkg.
`timescale 1ns / 1ps

module tcpck_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tcpck_pkg::fifo_ctl_t  ctl,
	input  tcpck_pkg::seg_desc_t  wr_desc,
	output tcpck_pkg::seg_desc_t  rd_desc,
	output logic                  full,
	output logic                  not_empty
);
	import tcpck_pkg::*;

	seg_desc_t           mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wptr_q, rptr_q;
	logic [FIFO_AW:0]    count_q;

	assign full      = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_desc   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + {{FIFO_AW{1'b0}}, ctl.push} - {{FIFO_AW{1'b0}}, ctl.pop};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[wptr_q] <= wr_desc;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> !full) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> not_empty) else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue count out of range");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.push && !ctl.pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

endmodule

@@ hw/rtl/tcpck_back.sv @@
// Back end: assigns sequence numbers, builds header sums in three stages, output register.
// Depends on tcpck_pkg.
`timescale 1ns / 1ps

module tcpck_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           ack_value,
	input  logic                  desc_valid,
	input  tcpck_pkg::seg_desc_t  desc,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [15:0]           total_length,
	output logic [15:0]           ip_checksum,
	output logic [15:0]           tcp_checksum,
	output logic [31:0]           sequence_number,
	output logic                  too_long
);
	import tcpck_pkg::*;

	logic        en;
	logic [31:0] next_seq_q;

	logic        v_s1, v_s2, v_s3;
	logic [31:0] seq_s1, seq_s2, seq_s3;
	logic [15:0] total_s1, total_s2, total_s3;
	logic [15:0] tcp_len_s1, tcp_len_s2;
	logic        long_s1, long_s2, long_s3;
	logic [21:0] addr_sum_s1, hdr_sum_s1;
	logic [21:0] ip_raw_s2, tcp_raw_s2;
	logic [15:0] ip_ck_s3, tcp_ck_s3;

	logic        long_c;
	logic [15:0] total_c;

	assign en  = ~v_s3 | out_ready;
	assign pop = desc_valid & en;

	always_comb begin
		long_c  = desc.count > MAX_PAYLOAD;
		total_c = long_c ? LEN_SAT : HDR_BYTES + desc.count[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
		end else if (en) begin
			if (pop) begin
				next_seq_q <= next_seq_q + {15'b0, desc.count};
			end
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seq_s1      <= next_seq_q;
			total_s1    <= total_c;
			tcp_len_s1  <= total_c - IP_HDR_BYTES;
			long_s1     <= long_c;
			addr_sum_s1 <= {6'b0, desc.src_ip[31:16]} + {6'b0, desc.src_ip[15:0]}
				+ {6'b0, desc.dst_ip[31:16]} + {6'b0, desc.dst_ip[15:0]};
			hdr_sum_s1  <= {6'b0, desc.sum} + {6'b0, desc.ports[31:16]}
				+ {6'b0, desc.ports[15:0]} + {6'b0, ack_value[31:16]}
				+ {6'b0, ack_value[15:0]} + TCP_CONST_SUM;

			seq_s2     <= seq_s1;
			total_s2   <= total_s1;
			tcp_len_s2 <= tcp_len_s1;
			long_s2    <= long_s1;
			ip_raw_s2  <= addr_sum_s1 + {6'b0, total_s1} + IP_CONST_SUM;
			tcp_raw_s2 <= addr_sum_s1 + hdr_sum_s1 + {6'b0, seq_s1[31:16]}
				+ {6'b0, seq_s1[15:0]} + {6'b0, tcp_len_s1};

			seq_s3    <= seq_s2;
			total_s3  <= total_s2;
			long_s3   <= long_s2;
			ip_ck_s3  <= ~fold16(ip_raw_s2);
			tcp_ck_s3 <= ~fold16(tcp_raw_s2);
		end
	end

	assign out_valid       = v_s3;
	assign total_length    = total_s3;
	assign ip_checksum     = ip_ck_s3;
	assign tcp_checksum    = tcp_ck_s3;
	assign sequence_number = seq_s3;
	assign too_long        = long_s3;

	a_seq_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> $stable(next_seq_q)) else $error("sequence moved without a segment");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(v_s2)) else $error("pipeline moved during stall");
	a_sat_len: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && too_long) |-> total_length == LEN_SAT) else $error("oversize length not saturated");

endmodule

@@ hw/rtl/tcp_ipv4_header_checksum_gen_unit.sv @@
// Top level of the TCP/IPv4 header checksum generator.
// Depends on tcpck_pkg, tcpck_front, tcpck_fifo, tcpck_back.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one payload byte per transaction; tlast marks the final byte of a
//   segment. Addresses and ports in tdata are sampled with the first byte only.
//   m_axis carries one transaction per segment: total length, IPv4 header checksum,
//   TCP checksum and sequence number in tdata, the oversize flag in tuser.
//   cfg_we/cfg_wdata write the acknowledgment number; write only while idle.
// Throughput: one byte per cycle while the queue is not full, including back-to-back
//   one-byte segments. After the edge that accepted the final byte and wrote the
//   queue, the segment passes two sum stages, then the fold stage into the output
//   register; an m_axis stall holds it in place.
// The front end and the header pipeline are parted by a four-entry queue; when
//   m_axis stalls the pipeline holds, the queue fills, and s_axis_tready drops
//   only once the queue is full.
// Reset clears the sequence number, the acknowledgment number and all valid state;
//   the first segment after reset carries sequence number zero.
module tcp_ipv4_header_checksum_gen_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// payload_byte, source_ip, dest_ip, source_port, dest_port
	input  logic [103:0] s_axis_tdata,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// total_length, ip_checksum, tcp_checksum, sequence_number
	output logic [79:0]  m_axis_tdata,
	// too_long
	output logic [0:0]   m_axis_tuser
);
	import tcpck_pkg::*;

	logic        ack_q;
	logic [31:0] ack_value_q;
	logic        accept;
	logic        full, not_empty;
	fifo_ctl_t   ctl;
	seg_desc_t   wr_desc, rd_desc;
	logic        push, pop;
	logic        too_long;

	assign ack_q = cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_value_q <= '0;
		end else if (ack_q) begin
			ack_value_q <= cfg_wdata;
		end
	end

	assign s_axis_tready = ~full;
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign ctl.push      = push;
	assign ctl.pop       = pop;

	tcpck_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.payload_byte (s_axis_tdata[7:0]),
		.last_byte    (s_axis_tlast),
		.source_ip    (s_axis_tdata[39:8]),
		.dest_ip      (s_axis_tdata[71:40]),
		.source_port  (s_axis_tdata[87:72]),
		.dest_port    (s_axis_tdata[103:88]),
		.push         (push),
		.desc         (wr_desc)
	);

	tcpck_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.wr_desc   (wr_desc),
		.rd_desc   (rd_desc),
		.full      (full),
		.not_empty (not_empty)
	);

	tcpck_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.ack_value       (ack_value_q),
		.desc_valid      (not_empty),
		.desc            (rd_desc),
		.pop             (pop),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.total_length    (m_axis_tdata[15:0]),
		.ip_checksum     (m_axis_tdata[31:16]),
		.tcp_checksum    (m_axis_tdata[47:32]),
		.sequence_number (m_axis_tdata[79:48]),
		.too_long        (too_long)
	);

	assign m_axis_tuser = too_long;

endmodule
